// ===== design/sliding_window_min_max_assert.svh =====
// ---------------------------------------------------------------------------
// Sliding window min/max assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SWMM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sliding window min/max: assertion failed");

// antecedent implies consequent in the next cycle
`define SWMM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sliding window min/max: assertion failed");

`else

`define SWMM_ASSERT_IMP(lbl, ante, cons)
`define SWMM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/swmm_pkg.sv =====
// ---------------------------------------------------------------------------
// Sliding window min/max package
// Widths, defaults and the min/max token carried along the cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int CFG_W          = 7;
	localparam int WINDOW_MAX_DEF = 64;

	// running minimum and maximum handed from cell to cell
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
	} tok_t;

endpackage

`default_nettype wire

// ===== design/swmm_cell.sv =====
// ---------------------------------------------------------------------------
// Sliding window min/max cell
// Holds one stored sample and folds it into the passing min/max token.
// ---------------------------------------------------------------------------
`default_nettype none

module swmm_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  wire logic                                 clk,
	input  wire logic                                 shift_en,
	input  wire logic                                 step_en,
	input  wire logic [CW-1:0]                        eff_size,
	input  wire logic signed [swmm_pkg::SAMPLE_W-1:0] sample_in,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]      sample_out,
	input  wire swmm_pkg::tok_t                       tok_in,
	output swmm_pkg::tok_t                            tok_out
);
	import swmm_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_q;
	tok_t                       tok_q;
	tok_t                       tok_nxt;
	logic                       in_window;

	// cells past the window only pass the token on
	assign in_window = (CW'(INDEX) < eff_size);

	always_comb begin
		tok_nxt = tok_in;
		if (in_window) begin
			if (sample_q < tok_in.lo) begin
				tok_nxt.lo = sample_q;
			end
			if (sample_q > tok_in.hi) begin
				tok_nxt.hi = sample_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= sample_in;
		end
		if (step_en) begin
			tok_q <= tok_nxt;
		end
	end

	assign sample_out = sample_q;
	assign tok_out    = tok_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_min_max.sv =====
// ---------------------------------------------------------------------------
// Sliding window min/max
// Minimum and maximum of the last window_size signed samples of a stream.
// ---------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------
//  input    | in_valid / in_stall   | sample, start_sequence
//  output   | out_valid / out_stall | window_min, window_max
//  config   | cfg_write_en          | cfg_write_data (window_size)
//
//  A transaction that leaves the window short of full gives no result;
//  the next one may follow at once.
//  A transaction that completes a window holds in_stall while the
//  min/max token walks the cell chain, one cell a cycle, and the
//  result then lands in the output register. If the output register
//  is still stalled when the token reaches the tail, the token waits
//  there and the input stays stalled until it moves out.
//  Reset clears control and fill count only; stored samples are not cleared.
//
`default_nettype none

module sliding_window_min_max #(
	parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_write_en,
	input  wire logic [swmm_pkg::CFG_W-1:0]           cfg_write_data,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [swmm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                 start_sequence,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]      window_min,
	output logic signed [swmm_pkg::SAMPLE_W-1:0]      window_max
);
	import swmm_pkg::*;

	`include "sliding_window_min_max_assert.svh"

	// CW holds 0..WINDOW_MAX; EW is wide enough to compare against the register
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int EW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [EW-1:0] NMAX_E = EW'(WINDOW_MAX);
	localparam logic [CW-1:0] NMAX   = CW'(WINDOW_MAX);

	logic [CFG_W-1:0]    window_size_q;
	logic [CW-1:0]       fill_q;
	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;

	logic [EW-1:0]       ws_ext;
	logic [CW-1:0]       eff_size;
	logic                in_acc;
	logic [CW-1:0]       fill_base;
	logic [CW-1:0]       fill_nxt;
	logic                res_now;
	logic                at_tail;
	logic                step_en;
	logic                deliver;
	tok_t                seed;

	logic signed [SAMPLE_W-1:0] sample_chain [0:WINDOW_MAX];
	tok_t                       tok_chain    [0:WINDOW_MAX];

	// effective window: zero reads as one, oversize saturates
	assign ws_ext = EW'(window_size_q);
	always_comb begin
		if (window_size_q == '0) begin
			eff_size = CW'(1);
		end else if (ws_ext > NMAX_E) begin
			eff_size = NMAX;
		end else begin
			eff_size = CW'(ws_ext);
		end
	end

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	// fill count restarts on a sequence start and saturates at the chain length
	assign fill_base = start_sequence ? '0 : fill_q;
	assign fill_nxt  = (fill_base < NMAX) ? fill_base + CW'(1) : fill_base;
	assign res_now   = (fill_nxt >= eff_size);

	// token walks one cell a cycle; at the tail it waits for the output register
	assign at_tail = busy_q && (cnt_q == NMAX);
	assign step_en = busy_q && !at_tail;
	assign deliver = at_tail && (!out_valid_q || !out_stall);

	// neutral token: the newest sample in cell 0 wins both compares
	assign seed.lo = {1'b0, {(SAMPLE_W-1){1'b1}}};
	assign seed.hi = {1'b1, {(SAMPLE_W-1){1'b0}}};

	assign sample_chain[0] = sample;
	assign tok_chain[0]    = seed;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swmm_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.shift_en   (in_acc),
			.step_en    (step_en),
			.eff_size   (eff_size),
			.sample_in  (sample_chain[i]),
			.sample_out (sample_chain[i+1]),
			.tok_in     (tok_chain[i]),
			.tok_out    (tok_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= CFG_W'(1);
			fill_q        <= '0;
			busy_q        <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				window_size_q <= cfg_write_data;
			end
			if (in_acc) begin
				fill_q <= fill_nxt;
				if (res_now) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (step_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (deliver) begin
				busy_q <= 1'b0;
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			min_q <= tok_chain[WINDOW_MAX].lo;
			max_q <= tok_chain[WINDOW_MAX].hi;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_min = min_q;
	assign window_max = max_q;

	// a transaction that fills no window leaves the block free next cycle
	`SWMM_ASSERT_NXT(a_noresult_free, in_acc && !res_now, !busy_q)
	// the walk counter advances by one each cycle until the tail
	`SWMM_ASSERT_NXT(a_walk_step, step_en, busy_q && (cnt_q == $past(cnt_q) + CW'(1)))
	// a delivered token ends the walk and raises the result
	`SWMM_ASSERT_NXT(a_deliver, deliver, out_valid_q && !busy_q)
	// fill count never passes the chain length
	`SWMM_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= NMAX)

endmodule

`default_nettype wire
